FILE: rtl/bilp_pkg.sv
// Shared widths, codes and chain packet types for the binary ILP feasibility search.
package bilp_pkg;

  localparam int MAX_VARS_DEF  = 32;
  localparam int MAX_ROWS_DEF  = 32;
  localparam int COEF_BITS_DEF = 16;

  localparam int REQ_W     = 2;
  localparam int IDX_W     = 5;
  localparam int COEF_IN_W = 16;
  localparam int REL_W     = 2;
  localparam int BOUND_W   = 21;
  localparam int CAND_W    = 32;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int ROW_IDX_W = 6;

  localparam logic [REQ_W-1:0] REQ_COEF = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ROW  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TEST = 2'd2;

  localparam logic [REL_W-1:0] REL_LE = 2'd0;
  localparam logic [REL_W-1:0] REL_GE = 2'd1;
  localparam logic [REL_W-1:0] REL_EQ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_VARS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd1;

  // row tag, whose partial sum follows it in the next cycle
  typedef struct packed {
    logic                 vld;
    logic                 lst;
    logic [ROW_IDX_W-1:0] row;
  } lead_t;

  typedef struct packed {
    logic done;
    logic feasible;
  } res_t;

endpackage

FILE: rtl/bilp_cell.sv
// One column cell: holds a coefficient column and adds it into the passing row sum.
module bilp_cell #(
  parameter int MAX_ROWS  = bilp_pkg::MAX_ROWS_DEF,
  parameter int COEF_BITS = bilp_pkg::COEF_BITS_DEF,
  parameter int SUM_W     = 22
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [bilp_pkg::ROW_IDX_W-1:0] wr_row,
  input  logic [COEF_BITS-1:0]           wr_data,
  input  logic                           bit_sel,
  input  bilp_pkg::lead_t                lead_in,
  input  logic [SUM_W-1:0]               sum_in,
  output bilp_pkg::lead_t                lead_out,
  output logic [SUM_W-1:0]               sum_out
);
  import bilp_pkg::*;

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [COEF_BITS-1:0] mem [MAX_ROWS];
  logic [COEF_BITS-1:0] rd_r;
  lead_t                lead_r;
  logic [SUM_W-1:0]     sum_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row[RW-1:0]] <= wr_data;
    end
    rd_r <= mem[lead_in.row[RW-1:0]];
  end

  // the sum follows its row tag in the next cycle, matching the registered coefficient read
  always_ff @(posedge clk) begin
    sum_r <= sum_in + (bit_sel ? SUM_W'(rd_r) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= '0;
    end else begin
      lead_r <= lead_in;
    end
  end

  assign lead_out = lead_r;
  assign sum_out  = sum_r;

endmodule

FILE: rtl/bilp_check.sv
// Chain tail: holds row relations and bounds, checks each row sum and folds the verdict.
module bilp_check #(
  parameter int MAX_ROWS = bilp_pkg::MAX_ROWS_DEF,
  parameter int SUM_W    = 22
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [bilp_pkg::ROW_IDX_W-1:0] wr_row,
  input  logic [bilp_pkg::REL_W-1:0]     wr_rel,
  input  logic [bilp_pkg::BOUND_W-1:0]   wr_bound,
  input  bilp_pkg::lead_t                lead_in,
  input  logic [SUM_W-1:0]               sum_in,
  output bilp_pkg::res_t                 res
);
  import bilp_pkg::*;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CMP_W = (SUM_W > BOUND_W) ? SUM_W : BOUND_W;

  logic [REL_W+BOUND_W-1:0] mem [MAX_ROWS];
  logic [REL_W+BOUND_W-1:0] rb_r;
  logic                     vld_r;
  logic                     lst_r;
  logic                     ok_r;
  res_t                     res_r;
  logic [REL_W-1:0]         rel;
  logic [CMP_W-1:0]         lhs;
  logic [CMP_W-1:0]         rhs;
  logic                     hold;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row[RW-1:0]] <= {wr_rel, wr_bound};
    end
    rb_r <= mem[lead_in.row[RW-1:0]];
  end

  assign rel = rb_r[REL_W+BOUND_W-1:BOUND_W];
  assign lhs = CMP_W'(sum_in);
  assign rhs = CMP_W'(rb_r[BOUND_W-1:0]);

  always_comb begin
    case (rel)
      REL_LE:  hold = (lhs <= rhs);
      REL_GE:  hold = (lhs >= rhs);
      REL_EQ:  hold = (lhs == rhs);
      default: hold = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      lst_r <= 1'b0;
      ok_r  <= 1'b1;
      res_r <= '0;
    end else begin
      vld_r          <= lead_in.vld;
      lst_r          <= lead_in.lst;
      res_r.done     <= vld_r && lst_r;
      res_r.feasible <= ok_r && hold;
      // rearm the verdict after the final row of a candidate
      if (vld_r) begin
        ok_r <= lst_r ? 1'b1 : (ok_r && hold);
      end
    end
  end

  assign res = res_r;

endmodule

FILE: rtl/binary_ilp_feasibility_enum.sv
// Top level of the brute-force 0/1 integer program feasibility search.
// A test beat raises out_valid once its last row has crossed the chain and its bound check, and
// busy falls at the end of the strobe cycle, so no new beat is accepted until after that result:
// rows enter a chain of MAX_VARS column cells one per cycle and each row crosses every cell
// before its bound check.
// Write beats give no result. The receiver cannot stall; each result is shown for exactly
// one cycle. Stores need no clearing pass after reset.
module binary_ilp_feasibility_enum #(
  parameter int MAX_VARS  = bilp_pkg::MAX_VARS_DEF,
  parameter int MAX_ROWS  = bilp_pkg::MAX_ROWS_DEF,
  parameter int COEF_BITS = bilp_pkg::COEF_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [bilp_pkg::REQ_W-1:0]     in_req_type,
  input  logic [bilp_pkg::IDX_W-1:0]     in_row_index,
  input  logic [bilp_pkg::IDX_W-1:0]     in_col_index,
  input  logic [bilp_pkg::COEF_IN_W-1:0] in_coefficient,
  input  logic [bilp_pkg::REL_W-1:0]     in_relation,
  input  logic [bilp_pkg::BOUND_W-1:0]   in_bound,
  output logic                           out_valid,
  output logic [bilp_pkg::CAND_W-1:0]    out_candidate,
  output logic                           out_feasible,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bilp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bilp_pkg::CFG_W-1:0]     cfg_data
);
  import bilp_pkg::*;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SUM_W = COEF_BITS + $clog2(MAX_VARS + 1);

  logic [CFG_W-1:0]    num_vars_r;
  logic [CFG_W-1:0]    num_rows_r;
  logic [MAX_VARS-1:0] cnt_r;
  logic [MAX_VARS-1:0] vec_r;
  logic                fin_r;
  logic                busy_r;
  logic                iss_on_r;
  logic [RW-1:0]       iss_row_r;

  logic [CFG_W-1:0]    n_eff;
  logic [CFG_W-1:0]    m_eff;
  logic [MAX_VARS-1:0] mask;
  logic [MAX_VARS-1:0] vec;
  logic                fin;
  logic                accept;
  logic                test_go;
  logic                coef_we;
  logic                row_we;
  logic                iss_last;
  logic [ROW_IDX_W-1:0] wr_row;

  lead_t               lead [MAX_VARS+1];
  logic [SUM_W-1:0]    psum [MAX_VARS+1];
  res_t                res;

  assign n_eff = (num_vars_r == '0) ? CFG_W'(1) :
                 (int'(num_vars_r) > MAX_VARS) ? CFG_W'(MAX_VARS) : num_vars_r;
  assign m_eff = (num_rows_r == '0) ? CFG_W'(1) :
                 (int'(num_rows_r) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : num_rows_r;

  always_comb begin
    for (int k = 0; k < MAX_VARS; k++) begin
      mask[k] = (k < int'(n_eff));
    end
  end

  assign vec = cnt_r & mask;
  assign fin = (vec == mask);

  assign accept  = start && !busy_r;
  assign test_go = accept && (in_req_type == REQ_TEST);
  assign coef_we = accept && (in_req_type == REQ_COEF) &&
                   (int'(in_row_index) < MAX_ROWS) && (int'(in_col_index) < MAX_VARS);
  assign row_we  = accept && (in_req_type == REQ_ROW) && (int'(in_row_index) < MAX_ROWS);
  assign wr_row  = ROW_IDX_W'(in_row_index);

  assign iss_last = ((int'(iss_row_r) + 1) == int'(m_eff));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vars_r <= CFG_W'(1);
      num_rows_r <= CFG_W'(1);
      cnt_r      <= '0;
      busy_r     <= 1'b0;
      iss_on_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NUM_VARS: num_vars_r <= cfg_data;
          CFG_NUM_ROWS: num_rows_r <= cfg_data;
          default: ;
        endcase
      end
      if (test_go) begin
        busy_r   <= 1'b1;
        iss_on_r <= 1'b1;
        cnt_r    <= fin ? '0 : MAX_VARS'(vec + 1'b1);
      end else begin
        if (iss_on_r && iss_last) begin
          iss_on_r <= 1'b0;
        end
        if (res.done) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (test_go) begin
      vec_r     <= vec;
      fin_r     <= fin;
      iss_row_r <= '0;
    end else if (iss_on_r) begin
      iss_row_r <= RW'(iss_row_r + 1'b1);
    end
  end

  // feed one row tag per cycle into the head of the chain
  assign lead[0].vld = iss_on_r;
  assign lead[0].lst = iss_last;
  assign lead[0].row = ROW_IDX_W'(iss_row_r);
  assign psum[0]     = '0;

  for (genvar k = 0; k < MAX_VARS; k++) begin : g_cell
    bilp_cell #(
      .MAX_ROWS  (MAX_ROWS),
      .COEF_BITS (COEF_BITS),
      .SUM_W     (SUM_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (coef_we && (int'(in_col_index) == k)),
      .wr_row   (wr_row),
      .wr_data  (COEF_BITS'(in_coefficient)),
      .bit_sel  (vec_r[k]),
      .lead_in  (lead[k]),
      .sum_in   (psum[k]),
      .lead_out (lead[k+1]),
      .sum_out  (psum[k+1])
    );
  end

  bilp_check #(
    .MAX_ROWS (MAX_ROWS),
    .SUM_W    (SUM_W)
  ) u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (row_we),
    .wr_row   (wr_row),
    .wr_rel   (in_relation),
    .wr_bound (in_bound),
    .lead_in  (lead[MAX_VARS]),
    .sum_in   (psum[MAX_VARS]),
    .res      (res)
  );

  assign busy          = busy_r;
  assign cfg_ready     = 1'b1;
  assign out_valid     = res.done;
  assign out_feasible  = res.feasible;
  assign out_candidate = CAND_W'(vec_r);
  assign out_last      = fin_r;

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy_r)
    else $error("result beat outside a test");

  a_test_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    test_go |=> (busy_r && iss_on_r))
    else $error("accepted test did not start the row walk");

  a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy_r)
    else $error("block stayed busy after its result beat");

  a_no_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !iss_on_r)
    else $error("row issued while idle");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result beats in a row");

endmodule
